// ===== src/mpsm_pkg.sv =====
// Package: shared types, codes and constants of the string matcher
`default_nettype none
package mpsm_pkg;
	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam int MASK_BITS = 16;

	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_MAP     = 3'd1,
		KIND_CHAR    = 3'd2,
		KIND_LEN     = 3'd3,
		KIND_RESTART = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		REG_WORD_START = 2'd0,
		REG_DEFAULT_MAP = 2'd1,
		REG_TARGET_COUNT = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] map_index;
		logic [3:0] target_index;
		logic [4:0] char_pos;
		logic [7:0] value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] match_mask;
		logic [31:0] end_position;
	} out_item_t;

	typedef struct packed {
		logic load;       // latch input transaction
		logic shift;      // map and shift data byte
		logic compare;    // compare current target
		logic restart;
		logic write_map;
		logic write_char;
		logic write_len;
		logic emit;       // load output register
	} cmd_t;

	typedef struct packed {
		logic last_target;
		logic [2:0] kind;
	} status_t;

	function automatic logic [7:0] default_map(input logic [7:0] b);
		if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
				(b >= 8'h61 && b <= 8'h7a))
			return b;
		return SPACE_BYTE;
	endfunction
endpackage
`default_nettype wire

// ===== src/mpsm_datapath.sv =====
// Datapath: character table, target memory, history, comparator and result register
`default_nettype none
module mpsm_datapath #(
	parameter int MAX_TARGETS = 16,
	parameter int MAX_LEN = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mpsm_pkg::cmd_t     cmd,
	output mpsm_pkg::status_t       status,
	input  wire mpsm_pkg::in_item_t in_item,
	input  wire logic               word_start_mode,
	input  wire logic               use_default_map,
	input  wire logic [4:0]         target_count,
	output mpsm_pkg::out_item_t     out_item
);
	localparam int TW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int LW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int LENW = $clog2(MAX_LEN + 1);
	localparam int HD = MAX_LEN + 1;
	localparam int BSW = $clog2(HD + 1);
	localparam int NT = (MAX_TARGETS < mpsm_pkg::MASK_BITS) ? MAX_TARGETS : mpsm_pkg::MASK_BITS;
	localparam int NTW = $clog2(NT + 1);

	mpsm_pkg::in_item_t item_q;
	logic [7:0] map_mem [256];
	logic [MAX_LEN*8-1:0] tgt_mem [MAX_TARGETS];
	logic [LENW-1:0] len_q [MAX_TARGETS];
	logic [7:0] hist_q [HD];
	logic [BSW-1:0] seen_q;
	logic [31:0] pos_q;
	logic [7:0] map_rd_q;
	logic [MAX_LEN*8-1:0] tgt_rd_q;
	logic [TW-1:0] tidx_q;
	logic [15:0] mask_q;
	mpsm_pkg::out_item_t out_q;
	logic [NTW-1:0] n_lim;
	logic [7:0] mapped;
	logic hit;
	logic [LENW-1:0] cur_len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (cmd.load) begin
			item_q <= in_item;
		end
	end

	// memories: write from latched transaction, registered reads
	always_ff @(posedge clk) begin
		if (cmd.write_map)
			map_mem[item_q.map_index] <= item_q.value;
		map_rd_q <= map_mem[item_q.value];
	end

	always_ff @(posedge clk) begin
		if (cmd.write_char && 32'(item_q.target_index) < MAX_TARGETS &&
				32'(item_q.char_pos) < MAX_LEN)
			tgt_mem[TW'(item_q.target_index)][LW'(item_q.char_pos)*8 +: 8] <= item_q.value;
		tgt_rd_q <= tgt_mem[tidx_q];
	end

	always_comb begin
		if (target_count > 5'(NT))
			n_lim = NTW'(NT);
		else
			n_lim = NTW'(target_count);
	end

	assign status.kind = item_q.kind;
	assign status.last_target = (n_lim == '0) || (32'(tidx_q) + 1 >= 32'(n_lim));
	assign mapped = use_default_map ? mpsm_pkg::default_map(item_q.value) : map_rd_q;
	assign cur_len = len_q[tidx_q];

	always_comb begin
		hit = (cur_len != '0) && (32'(seen_q) >= 32'(cur_len));
		if (32'(tidx_q) >= 32'(n_lim)) hit = 1'b0;
		for (int k = 0; k < MAX_LEN; k++) begin
			if (k < 32'(cur_len) &&
					hist_q[LENW'(32'(cur_len) - 1 - k)] != tgt_rd_q[k*8 +: 8])
				hit = 1'b0;
		end
		if (word_start_mode && 32'(seen_q) != 32'(cur_len) &&
				hist_q[cur_len] != mpsm_pkg::SPACE_BYTE)
			hit = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TARGETS; i++) len_q[i] <= '0;
			for (int i = 0; i < HD; i++) hist_q[i] <= mpsm_pkg::SPACE_BYTE;
			seen_q <= '0;
			pos_q <= '0;
			tidx_q <= '0;
			mask_q <= '0;
		end else begin
			if (cmd.write_len && 32'(item_q.target_index) < MAX_TARGETS)
				len_q[TW'(item_q.target_index)] <= (32'(item_q.value) > MAX_LEN) ?
					LENW'(MAX_LEN) : LENW'(item_q.value);
			if (cmd.restart) begin
				for (int i = 0; i < HD; i++) hist_q[i] <= mpsm_pkg::SPACE_BYTE;
				seen_q <= '0;
				pos_q <= '0;
			end
			if (cmd.shift) begin
				for (int i = 1; i < HD; i++) hist_q[i] <= hist_q[i-1];
				hist_q[0] <= mapped;
				if (32'(seen_q) < HD) seen_q <= seen_q + 1'b1;
				tidx_q <= '0;
				mask_q <= '0;
			end
			if (cmd.compare) begin
				if (hit) mask_q[tidx_q] <= 1'b1;
				tidx_q <= tidx_q + 1'b1;
			end
			if (cmd.emit) pos_q <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.match_mask <= mask_q;
			out_q.end_position <= pos_q;
		end
	end

	assign out_item = out_q;
endmodule
`default_nettype wire

// ===== src/mpsm_ctrl.sv =====
// Controller: decodes a transaction, runs map, shift, compare, emit for data
`default_nettype none
module mpsm_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire mpsm_pkg::status_t status,
	output mpsm_pkg::cmd_t         cmd
);
	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DECODE  = 6'b000010,
		S_MAP     = 6'b000100,
		S_SHIFT   = 6'b001000,
		S_COMPARE = 6'b010000,
		S_LAST    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				case (status.kind)
					mpsm_pkg::KIND_DATA:    state_d = S_MAP;
					mpsm_pkg::KIND_MAP:     cmd.write_map = 1'b1;
					mpsm_pkg::KIND_CHAR:    cmd.write_char = 1'b1;
					mpsm_pkg::KIND_LEN:     cmd.write_len = 1'b1;
					mpsm_pkg::KIND_RESTART: cmd.restart = 1'b1;
					default:                state_d = S_IDLE;
				endcase
			end
			S_MAP: begin
				cmd.shift = 1'b1;
				state_d = S_SHIFT;
			end
			S_SHIFT: begin
				state_d = S_COMPARE;
			end
			S_COMPARE: begin
				cmd.compare = 1'b1;
				if (status.last_target) state_d = S_LAST;
				else state_d = S_SHIFT;
			end
			S_LAST: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

// ===== src/multi_pattern_string_matcher_unit.sv =====
// Top level of the multi-pattern string matcher
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | in_item  (mpsm_pkg::in_item_t)
//  out     | out | out_valid/out_ready| out_item (mpsm_pkg::out_item_t)
//  cfg     | in  | cfg_we             | cfg_index, cfg_data
// Loads and restarts pass only decode; a data byte passes map, then shift and
// compare per target in use, then last (one compare when no target is in use).
// Compare rate is set by one target-memory word read per target.
// Reset clears history, lengths and counters; tables and result are undefined.
// A result waits in the output register; the next byte stalls only at emit.
`default_nettype none
module multi_pattern_string_matcher_unit #(
	parameter int MAX_TARGETS = 16,
	parameter int MAX_LEN = 32
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire mpsm_pkg::in_item_t in_item,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output mpsm_pkg::out_item_t     out_item,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [4:0]         cfg_data
);
	mpsm_pkg::cmd_t cmd;
	mpsm_pkg::status_t status;
	logic word_start_q, default_map_q;
	logic [4:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_start_q <= 1'b0;
			default_map_q <= 1'b1;
			count_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				mpsm_pkg::REG_WORD_START:   word_start_q <= cfg_data[0];
				mpsm_pkg::REG_DEFAULT_MAP:  default_map_q <= cfg_data[0];
				mpsm_pkg::REG_TARGET_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mpsm_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready,
		.status, .cmd
	);

	mpsm_datapath #(.MAX_TARGETS(MAX_TARGETS), .MAX_LEN(MAX_LEN)) u_dp (
		.clk, .arst_n, .cmd, .status, .in_item,
		.word_start_mode(word_start_q), .use_default_map(default_map_q),
		.target_count(count_q), .out_item
	);
endmodule
`default_nettype wire

// ===== src/mpsm_checker.sv =====
// Port checker for the string matcher, bound to the top level
`default_nettype none
module mpsm_assertions (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire mpsm_pkg::out_item_t out_item
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output changed while stalled");
	a_no_accept_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted two transactions back to back");
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result raised right after an input transaction");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_ready, out_valid}))
		else $error("handshake output unknown");
endmodule

bind multi_pattern_string_matcher_unit mpsm_assertions u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_item
);
`default_nettype wire

// ===== dv/mpsm_checker.sv =====
// Checker: predicts string matcher results and compares them on the output channel
`timescale 1ns / 100ps
`default_nettype none
module mpsm_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire mpsm_pkg::in_item_t  in_item,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire mpsm_pkg::out_item_t out_item,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [4:0]          cfg_data,
	output int                       errors,
	output int                       pending,
	output int                       results_seen,
	output int                       hits_seen
);
	localparam int NUM_TGT = 16;
	localparam int LEN_MAX = 32;

	logic        word_start;
	logic        dflt_map;
	logic [4:0]  tgt_count;
	logic [7:0]  xlat_tbl [256];
	logic [7:0]  tgt_char [NUM_TGT][LEN_MAX];
	logic [5:0]  tgt_len [NUM_TGT];
	logic [7:0]  hist [LEN_MAX + 1];
	int          seen;
	logic [31:0] offset;
	mpsm_pkg::out_item_t match_q[$];

	function automatic logic [7:0] fold_byte(input logic [7:0] b);
		if (!dflt_map)
			return xlat_tbl[b];
		if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
			return b;
		return mpsm_pkg::SPACE_BYTE;
	endfunction

	function automatic logic ends_at_byte(input int t);
		int len;
		len = tgt_len[t];
		if (len == 0 || seen < len)
			return 1'b0;
		for (int k = 0; k < len; k++)
			if (hist[len - 1 - k] != tgt_char[t][k])
				return 1'b0;
		if (word_start && seen != len && hist[len] != mpsm_pkg::SPACE_BYTE)
			return 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int n;
		int err_n;
		mpsm_pkg::out_item_t exp_item;
		mpsm_pkg::out_item_t got;
		if (!arst_n) begin
			word_start = 1'b0;
			dflt_map = 1'b1;
			tgt_count = '0;
			foreach (tgt_len[i]) tgt_len[i] = '0;
			foreach (hist[i]) hist[i] = mpsm_pkg::SPACE_BYTE;
			seen = 0;
			offset = '0;
			match_q.delete();
			errors <= 0;
			pending <= 0;
			results_seen <= 0;
			hits_seen <= 0;
		end else begin
			err_n = 0;
			if (out_valid && out_ready) begin
				got = out_item;
				results_seen <= results_seen + 1;
				if (got.match_mask != 0)
					hits_seen <= hits_seen + 1;
				if (match_q.size() == 0) begin
					$error("unexpected result: mask %h position %0d",
						got.match_mask, got.end_position);
					err_n++;
				end else begin
					exp_item = match_q.pop_front();
					if (got.match_mask !== exp_item.match_mask) begin
						$error("match_mask: expected %h, actual %h",
							exp_item.match_mask, got.match_mask);
						err_n++;
					end
					if (got.end_position !== exp_item.end_position) begin
						$error("end_position: expected %0d, actual %0d",
							exp_item.end_position, got.end_position);
						err_n++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					mpsm_pkg::REG_WORD_START:   word_start = cfg_data[0];
					mpsm_pkg::REG_DEFAULT_MAP:  dflt_map = cfg_data[0];
					mpsm_pkg::REG_TARGET_COUNT: tgt_count = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (in_item.kind)
					mpsm_pkg::KIND_DATA: begin
						for (int i = LEN_MAX; i > 0; i--)
							hist[i] = hist[i - 1];
						hist[0] = fold_byte(in_item.value);
						if (seen < LEN_MAX + 1)
							seen++;
						n = (tgt_count > NUM_TGT) ? NUM_TGT : tgt_count;
						exp_item.match_mask = '0;
						for (int t = 0; t < n; t++)
							exp_item.match_mask[t] = ends_at_byte(t);
						exp_item.end_position = offset;
						offset = offset + 1;
						match_q.push_back(exp_item);
					end
					mpsm_pkg::KIND_MAP: xlat_tbl[in_item.map_index] = in_item.value;
					mpsm_pkg::KIND_CHAR:
						tgt_char[in_item.target_index][in_item.char_pos] = in_item.value;
					mpsm_pkg::KIND_LEN: tgt_len[in_item.target_index] =
						(in_item.value > LEN_MAX) ? 6'(LEN_MAX) : in_item.value[5:0];
					mpsm_pkg::KIND_RESTART: begin
						foreach (hist[i]) hist[i] = mpsm_pkg::SPACE_BYTE;
						seen = 0;
						offset = '0;
					end
					default: ;
				endcase
			end
			if (err_n != 0)
				errors <= errors + err_n;
			pending <= match_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== dv/tb_multi_pattern_string_matcher_unit.sv =====
// Testbench top: stimulus, idling, watchdog and verdict for the string matcher
`timescale 1ns / 100ps
`default_nettype none
module tb_multi_pattern_string_matcher_unit;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 50;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	mpsm_pkg::in_item_t  in_item = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	mpsm_pkg::out_item_t out_item;
	logic       cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	int errors, pending, results_seen, hits_seen;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	logic [7:0] tgt_shadow [16][32];
	int len_shadow [16];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multi_pattern_string_matcher_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	mpsm_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending),
		.results_seen(results_seen), .hits_seen(hits_seen)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic [7:0] pick_char();
		case ($urandom_range(3))
			0: return "a";
			1: return "b";
			2: return "a";
			default: return "c";
		endcase
	endfunction

	function automatic logic [7:0] plain_fold(input logic [7:0] b);
		if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z"))
			return b;
		return mpsm_pkg::SPACE_BYTE;
	endfunction

	// start at a posedge; return at the posedge that accepts the transaction
	task automatic push_item(input logic [2:0] kind, input logic [7:0] mi,
			input logic [3:0] ti, input logic [4:0] cp, input logic [7:0] v);
		mpsm_pkg::in_item_t it;
		it.kind = kind;
		it.map_index = mi;
		it.target_index = ti;
		it.char_pos = cp;
		it.value = v;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		items_sent++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_item(mpsm_pkg::KIND_DATA, 8'($urandom), 4'($urandom), 5'($urandom), b);
	endtask

	task automatic push_len(input logic [3:0] t, input logic [7:0] v);
		push_item(mpsm_pkg::KIND_LEN, 8'($urandom), t, 5'($urandom), v);
		len_shadow[t] = (v > 32) ? 32 : v;
	endtask

	task automatic push_char(input logic [3:0] t, input logic [4:0] p, input logic [7:0] v);
		push_item(mpsm_pkg::KIND_CHAR, 8'($urandom), t, p, v);
		tgt_shadow[t][p] = v;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	task automatic set_regs(input logic ws, input logic dm, input logic [4:0] tc);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= mpsm_pkg::REG_WORD_START;
		cfg_data <= {4'b0, ws};
		@(posedge clk);
		cfg_index <= mpsm_pkg::REG_DEFAULT_MAP;
		cfg_data <= {4'b0, dm};
		@(posedge clk);
		cfg_index <= mpsm_pkg::REG_TARGET_COUNT;
		cfg_data <= tc;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_items(input int count, input logic pause_once);
		int stop, r, t;
		logic paused;
		stop = items_sent + count;
		paused = 1'b0;
		while (items_sent < stop) begin
			if (pause_once && !paused && items_sent >= stop - count / 2) begin
				drain();
				paused = 1'b1;
			end
			r = $urandom_range(99);
			t = $urandom_range(15);
			if (r < 8)
				push_item(mpsm_pkg::KIND_MAP, 8'(t * 16 + $urandom_range(15)), 4'($urandom),
					5'($urandom), ($urandom_range(1) != 0) ? plain_fold(8'(t * 16)) : 8'($urandom));
			else if (r < 14)
				push_char(4'(t), 5'($urandom), ($urandom_range(9) == 0) ? 8'($urandom) : pick_char());
			else if (r < 20)
				push_len(4'(t), (t == 13 || t == 14) ? 8'($urandom) : 8'($urandom_range(0, 8)));
			else if (r < 23)
				push_item(mpsm_pkg::KIND_RESTART, 8'($urandom), 4'($urandom), 5'($urandom),
					8'($urandom));
			else if (r < 25)
				push_item(3'($urandom_range(5, 7)), 8'($urandom), 4'($urandom), 5'($urandom),
					8'($urandom));
			else if (r < 50) begin
				if ($urandom_range(1) != 0)
					push_byte(" ");
				for (int k = 0; k < len_shadow[t]; k++)
					push_byte(tgt_shadow[t][k]);
			end else
				push_byte(($urandom_range(9) < 7) ? pick_char() : 8'($urandom));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int t = 0; t < 16; t++)
			for (int p = 0; p < 8; p++)
				push_char(4'(t), 5'(p), pick_char());
		for (int p = 8; p < 32; p++) begin
			push_char(4'd13, 5'(p), pick_char());
			push_char(4'd14, 5'(p), pick_char());
		end
		for (int i = 0; i < 256; i++)
			push_item(mpsm_pkg::KIND_MAP, 8'(i), 4'($urandom), 5'($urandom), plain_fold(8'(i)));
		for (int t = 0; t < 16; t++)
			push_len(4'(t), 8'($urandom_range(1, 4)));

		set_regs(1'b0, 1'b1, 5'd16);
		push_byte(8'h00);
		push_byte(8'hff);
		push_byte("0");
		push_byte("9");
		push_byte("Z");
		push_byte("z");
		push_item(mpsm_pkg::KIND_MAP, 8'hff, 4'hf, 5'h1f, 8'hff);
		push_item(mpsm_pkg::KIND_MAP, 8'h00, 4'h0, 5'h00, 8'h00);
		push_char(4'd15, 5'd31, 8'hff);
		push_len(4'd15, 8'd0);
		push_len(4'd14, 8'd255);
		push_len(4'd13, 8'd33);
		push_item(3'd5, 8'hff, 4'hf, 5'h1f, 8'hff);
		push_item(3'd6, 8'h00, 4'h0, 5'h00, 8'h00);
		push_item(3'd7, 8'hff, 4'hf, 5'h1f, 8'hff);
		push_item(mpsm_pkg::KIND_RESTART, 8'hff, 4'hf, 5'h1f, 8'hff);
		for (int k = 0; k < len_shadow[0]; k++)
			push_byte(tgt_shadow[0][k]);
		push_byte(" ");
		for (int k = 0; k < len_shadow[1]; k++)
			push_byte(tgt_shadow[1][k]);

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_regs(1'b0, 1'b1, 5'd16);
				1: set_regs(1'b1, 1'b1, 5'd16);
				2: set_regs(1'b0, 1'b0, 5'd16);
				3: set_regs(1'b1, 1'b0, 5'd5);
				4: set_regs(1'b0, 1'b1, 5'd0);
				5: set_regs(1'b1, 1'b1, 5'd31);
				default: set_regs(1'b0, 1'b0, 5'd1);
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 45; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 45; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			random_items(32, ph == 2);
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d input transactions, %0d results, %0d with matches,",
			items_sent, results_seen, hits_seen);
		$display("across word-start, table and target-count settings under idle and stall.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
